[rtl/core/dcfi_pkg.sv]
// ----------------------------------------------------------------------------
// dcfi_pkg
// Shared types and constants for the unwind-table CFI encoder.
// ----------------------------------------------------------------------------
package dcfi_pkg;

  localparam int unsigned BufferBytes = 65536;
  localparam int unsigned PosW        = 17;

  // event codes
  localparam logic [2:0] EV_INIT     = 3'd0;
  localparam logic [2:0] EV_BEGIN    = 3'd1;
  localparam logic [2:0] EV_PUSH     = 3'd2;
  localparam logic [2:0] EV_CFA_REG  = 3'd3;
  localparam logic [2:0] EV_CFA_OFF  = 3'd4;
  localparam logic [2:0] EV_SAVE     = 3'd5;
  localparam logic [2:0] EV_END_FN   = 3'd6;
  localparam logic [2:0] EV_FINALIZE = 3'd7;

  // DW_CFA opcodes
  localparam logic [7:0] CFA_NOP         = 8'h00;
  localparam logic [7:0] CFA_ADV1        = 8'h02;
  localparam logic [7:0] CFA_ADV2        = 8'h03;
  localparam logic [7:0] CFA_ADV4        = 8'h04;
  localparam logic [7:0] CFA_REG_SAVE_X  = 8'h05;
  localparam logic [7:0] CFA_DEF_CFA     = 8'h0C;
  localparam logic [7:0] CFA_DEF_CFA_OFS = 8'h0E;
  localparam logic [7:0] CFA_ADVANCE     = 8'h40;
  localparam logic [7:0] CFA_REG_SAVE    = 8'h80;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
  } beat_t;

  typedef struct packed {
    logic  push;
    logic  flush;
    beat_t beat;
  } obuf_ctl_t;

endpackage

[rtl/core/dwarf_cfi_frame_encoder.sv]
// ----------------------------------------------------------------------------
// dwarf_cfi_frame_encoder
// Turns frame events into unwind-table byte writes (address, value).
// ----------------------------------------------------------------------------
// Each event is run by a small sequencer over a list of fields; one shared
// shifter/adder emits one byte write per cycle while output is not stalled.
// An event passes through the accepting beat, every sequencer step (skipped and
// dropped fields and the closing step included), its byte writes, the padding
// nops and the four-byte length patch, and a final flush; s_tready is low
// meanwhile. The last write of an event carries m_tlast.
// Length fields are patched after padding, as writes to lower addresses.
module dwarf_cfi_frame_encoder import dcfi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [143:0] s_tdata_i,  // reg_req[15:0], offset[46:16], code_pos[77:47],
                                   // func_addr[109:78], func_size[141:110], zeros
  input  logic [2:0]   s_tuser_i,  // func
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [23:0]  m_tdata_o,  // byte_addr[15:0], byte_value[23:16]
  output logic         m_tlast_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_PATCH = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;

  localparam logic [1:0] OP_END  = 2'd0;
  localparam logic [1:0] OP_SKIP = 2'd1;
  localparam logic [1:0] OP_GRP  = 2'd2;
  localparam logic [1:0] OP_PADP = 2'd3;

  localparam logic [PosW:0] CapLim = (PosW+1)'(BufferBytes);

  logic [2:0]      state_q;
  logic [4:0]      step_q;
  logic [2:0]      func_q;
  logic [15:0]     reg_q;
  logic [30:0]     off_q, code_q;
  logic [31:0]     addr_q, size_q;
  logic [PosW-1:0] wp_q, cie_q, fde_q, start_q;
  logic            cie_none_q, fde_none_q;
  logic [30:0]     last_q, delta_q;
  logic            adv_q;
  logic [31:0]     sh_q;
  logic [2:0]      cnt_q;
  logic            uleb_q;

  logic [1:0]  op_k;
  logic [31:0] op_val;
  logic [2:0]  op_len;
  logic        op_uleb;
  logic        op_adv;
  logic        adv_go;
  logic [30:0] delta;
  logic [2:0]  uleb_len, glen;
  logic        fits;
  logic        pad_need, patch_ok;
  logic        ob_ready, ob_pend;
  obuf_ctl_t   ctl;
  logic        accept;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);
  assign s_tready_o = (state_q == ST_IDLE);

  assign adv_go = code_q > last_q;
  assign delta  = code_q - last_q;

  always_comb begin
    op_k    = OP_END;
    op_val  = '0;
    op_len  = 3'd1;
    op_uleb = 1'b0;
    op_adv  = 1'b0;
    if ((func_q == EV_PUSH || func_q == EV_CFA_REG || func_q == EV_CFA_OFF ||
         func_q == EV_SAVE) && step_q == 5'd0) begin
      op_adv = 1'b1;
      if (!adv_go) begin
        op_k = OP_SKIP;
      end else begin
        op_k = OP_GRP;
        if (delta <= 31'd63)         op_val = {24'd0, CFA_ADVANCE | {2'b00, delta[5:0]}};
        else if (delta <= 31'd255)   op_val = {24'd0, CFA_ADV1};
        else if (delta <= 31'd65535) op_val = {24'd0, CFA_ADV2};
        else                         op_val = {24'd0, CFA_ADV4};
      end
    end else if ((func_q == EV_PUSH || func_q == EV_CFA_REG || func_q == EV_CFA_OFF ||
                  func_q == EV_SAVE) && step_q == 5'd1) begin
      if (!adv_q || delta_q <= 31'd63) begin
        op_k = OP_SKIP;
      end else begin
        op_k   = OP_GRP;
        op_val = {1'b0, delta_q};
        if (delta_q <= 31'd255)        op_len = 3'd1;
        else if (delta_q <= 31'd65535) op_len = 3'd2;
        else                           op_len = 3'd4;
      end
    end else begin
      case (func_q)
        EV_INIT: begin
          op_k = OP_GRP;
          case (step_q)
            5'd0, 5'd1: op_len = 3'd4;
            5'd2:  op_val = 32'd1;
            5'd3:  op_val = 32'h7A;
            5'd4:  op_val = 32'h52;
            5'd5:  op_val = 32'd0;
            5'd6:  begin op_val = 32'd1;  op_uleb = 1'b1; end
            5'd7:  op_val = 32'h78;
            5'd8:  begin op_val = 32'd16; op_uleb = 1'b1; end
            5'd9:  begin op_val = 32'd1;  op_uleb = 1'b1; end
            5'd10: op_val = 32'h1B;
            5'd11: op_val = {24'd0, CFA_DEF_CFA};
            5'd12: begin op_val = 32'd7;  op_uleb = 1'b1; end
            5'd13: begin op_val = 32'd8;  op_uleb = 1'b1; end
            5'd14: op_val = {24'd0, CFA_REG_SAVE | 8'd16};
            5'd15: begin op_val = 32'd1;  op_uleb = 1'b1; end
            5'd16: begin op_k = OP_PADP; op_val = {15'd0, cie_q}; end
            default: op_k = OP_END;
          endcase
        end
        EV_BEGIN: begin
          op_k   = OP_GRP;
          op_len = 3'd4;
          case (step_q)
            5'd0: op_val = '0;
            5'd1: op_val = cie_none_q ? {15'd0, wp_q} + 32'd1
                                      : {15'd0, wp_q} - {15'd0, cie_q};
            5'd2: op_val = addr_q;
            5'd3: op_val = size_q;
            5'd4: begin op_len = 3'd1; op_uleb = 1'b1; end
            default: op_k = OP_END;
          endcase
        end
        EV_PUSH: begin
          case (step_q)
            5'd2: begin
              op_k   = OP_GRP;
              op_val = (reg_q <= 16'd63) ? {24'd0, CFA_REG_SAVE | reg_q[7:0]}
                                         : {24'd0, CFA_REG_SAVE_X};
            end
            5'd3: begin
              op_k    = (reg_q <= 16'd63) ? OP_SKIP : OP_GRP;
              op_val  = {16'd0, reg_q};
              op_uleb = 1'b1;
            end
            5'd4: begin op_k = OP_GRP; op_val = 32'd1; op_uleb = 1'b1; end
            default: op_k = OP_END;
          endcase
        end
        EV_CFA_REG: begin
          op_k    = OP_GRP;
          op_uleb = 1'b1;
          case (step_q)
            5'd2: begin op_val = {24'd0, CFA_DEF_CFA}; op_uleb = 1'b0; end
            5'd3: op_val = {16'd0, reg_q};
            5'd4: op_val = {1'b0, off_q};
            default: op_k = OP_END;
          endcase
        end
        EV_CFA_OFF: begin
          op_k    = OP_GRP;
          op_uleb = 1'b1;
          case (step_q)
            5'd2: begin op_val = {24'd0, CFA_DEF_CFA_OFS}; op_uleb = 1'b0; end
            5'd3: op_val = {1'b0, off_q};
            default: op_k = OP_END;
          endcase
        end
        EV_SAVE: begin
          op_k    = OP_GRP;
          op_uleb = 1'b1;
          case (step_q)
            5'd2: begin op_val = {24'd0, CFA_REG_SAVE_X}; op_uleb = 1'b0; end
            5'd3: op_val = {16'd0, reg_q};
            5'd4: op_val = {4'd0, off_q[30:3]};
            default: op_k = OP_END;
          endcase
        end
        EV_END_FN: begin
          if (step_q == 5'd0 && !fde_none_q) begin
            op_k   = OP_PADP;
            op_val = {15'd0, fde_q};
          end
        end
        default: begin
          if (step_q == 5'd0) begin
            op_k   = OP_GRP;
            op_len = 3'd4;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (op_val < 32'h80)            uleb_len = 3'd1;
    else if (op_val < 32'h4000)     uleb_len = 3'd2;
    else if (op_val < 32'h20_0000)  uleb_len = 3'd3;
    else if (op_val < 32'h1000_0000) uleb_len = 3'd4;
    else                            uleb_len = 3'd5;
  end

  assign glen     = op_uleb ? uleb_len : op_len;
  assign fits     = ({1'b0, wp_q} + {{(PosW-2){1'b0}}, glen}) <= CapLim;
  assign pad_need = (wp_q[2:0] != start_q[2:0]) && ({1'b0, wp_q} < CapLim);
  assign patch_ok = ({1'b0, start_q} + (PosW+1)'(4)) <= CapLim;

  always_comb begin
    ctl = '0;
    case (state_q)
      ST_EMIT: begin
        ctl.push       = ob_ready;
        ctl.beat.addr  = wp_q[15:0];
        ctl.beat.value = uleb_q ? {(cnt_q != 3'd1), sh_q[6:0]} : sh_q[7:0];
      end
      ST_PAD: begin
        ctl.push       = ob_ready && pad_need;
        ctl.beat.addr  = wp_q[15:0];
        ctl.beat.value = CFA_NOP;
      end
      ST_PATCH: begin
        ctl.push       = ob_ready;
        ctl.beat.addr  = start_q[15:0] + {14'd0, cnt_q[1:0]};
        ctl.beat.value = sh_q[7:0];
      end
      ST_END: ctl.flush = ob_ready && ob_pend;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      wp_q       <= '0;
      cie_q      <= '0;
      cie_none_q <= 1'b1;
      fde_q      <= '0;
      fde_none_q <= 1'b1;
      last_q     <= '0;
      adv_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            step_q  <= '0;
            state_q <= ST_FETCH;
            if (s_tuser_i == EV_INIT) begin
              wp_q       <= '0;
              fde_none_q <= 1'b1;
              last_q     <= '0;
              cie_q      <= '0;
              cie_none_q <= 1'b0;
            end else if (s_tuser_i == EV_BEGIN) begin
              fde_q      <= wp_q;
              fde_none_q <= 1'b0;
              last_q     <= '0;
            end
          end
        end
        ST_FETCH: begin
          if (op_adv) begin
            adv_q <= adv_go;
            if (adv_go) begin
              delta_q <= delta;
              last_q  <= code_q;
            end
          end
          case (op_k)
            OP_END:  state_q <= ST_END;
            OP_SKIP: step_q <= step_q + 5'd1;
            OP_GRP: begin
              if (fits) begin
                sh_q    <= op_val;
                cnt_q   <= glen;
                uleb_q  <= op_uleb;
                state_q <= ST_EMIT;
              end else begin
                step_q <= step_q + 5'd1;
              end
            end
            default: begin
              start_q    <= op_val[PosW-1:0];
              fde_none_q <= 1'b1;
              state_q    <= ST_PAD;
            end
          endcase
        end
        ST_EMIT: begin
          if (ob_ready) begin
            wp_q  <= wp_q + PosW'(1);
            sh_q  <= uleb_q ? (sh_q >> 7) : (sh_q >> 8);
            cnt_q <= cnt_q - 3'd1;
            if (cnt_q == 3'd1) begin
              step_q  <= step_q + 5'd1;
              state_q <= ST_FETCH;
            end
          end
        end
        ST_PAD: begin
          if (pad_need) begin
            if (ob_ready) wp_q <= wp_q + PosW'(1);
          end else if (patch_ok) begin
            // entry length excludes the length word itself
            sh_q    <= {15'd0, wp_q} - {15'd0, start_q} - 32'd4;
            cnt_q   <= '0;
            state_q <= ST_PATCH;
          end else begin
            step_q  <= step_q + 5'd1;
            state_q <= ST_FETCH;
          end
        end
        ST_PATCH: begin
          if (ob_ready) begin
            sh_q  <= sh_q >> 8;
            cnt_q <= cnt_q + 3'd1;
            if (cnt_q == 3'd3) begin
              step_q  <= step_q + 5'd1;
              state_q <= ST_FETCH;
            end
          end
        end
        ST_END: begin
          if (!ob_pend || ob_ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_tuser_i;
      reg_q  <= s_tdata_i[15:0];
      off_q  <= s_tdata_i[46:16];
      code_q <= s_tdata_i[77:47];
      addr_q <= s_tdata_i[109:78];
      size_q <= s_tdata_i[141:110];
    end
  end

  dcfi_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .ready_o    (ob_ready),
    .pend_o     (ob_pend),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

`ifndef SYNTHESIS
  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} <= CapLim) else $error("write position past capacity");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !ob_pend) else $error("byte held while idle");
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q != 3'd0) else $error("emit with empty count");
`endif

endmodule

[rtl/core/dcfi_obuf.sv]
// ----------------------------------------------------------------------------
// dcfi_obuf
// Holds the newest byte write until the next one shows whether it is last.
// ----------------------------------------------------------------------------
module dcfi_obuf import dcfi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  obuf_ctl_t   ctl_i,
  output logic        ready_o,
  output logic        pend_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // byte_addr[15:0], byte_value[23:16]
  output logic        m_tlast_o
);

  logic  pend_q;
  beat_t pend_beat_q;
  logic  out_v_q;
  logic  out_last_q;
  beat_t out_beat_q;
  logic  move;

  assign ready_o = !out_v_q || m_tready_i;
  assign move    = ready_o && pend_q && (ctl_i.push || ctl_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready_o && ctl_i.push) begin
        pend_q <= 1'b1;
      end else if (ready_o && ctl_i.flush) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (m_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.push) begin
      pend_beat_q <= ctl_i.beat;
    end
    if (move) begin
      out_beat_q <= pend_beat_q;
      out_last_q <= ctl_i.flush && !ctl_i.push;
    end
  end

  assign pend_o     = pend_q;
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {out_beat_q.value, out_beat_q.addr};
  assign m_tlast_o  = out_last_q;

endmodule
